// ----- hw/rtl/fpdds_pkg.sv -----
// Shared types, constants and helpers for the four-phase DDS DAC driver.
// No dependencies; imported by four_phase_dds_dac_driver.
package fpdds_pkg;

  // Default waveform table depth.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Payload widths of the stream and configuration ports.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Field widths.
  localparam int TADDR_W  = 10;
  localparam int CODE_W   = 16;
  localparam int SPEED_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int SCALE_W  = 16;
  localparam int PHASE_W  = 32;
  localparam int WORD_W   = 32;
  localparam int CHAN_W   = 2;

  // DAC command codes.
  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_LOAD_LATCH = 3'd2;

  // Highest channel; its word closes a tick.
  localparam logic [CHAN_W-1:0] CHAN_LAST = 2'd3;

  // Half a turn of the phase accumulator.
  localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

  // Configuration register select (byte address bit 2).
  localparam logic REG_SPEED_LIMIT = 1'b0;
  localparam logic REG_FREQ_SCALE  = 1'b1;

  // Item modes carried on in_tuser.
  typedef enum logic [1:0] {
    MODE_TABLE_WRITE = 2'd0,
    MODE_SET_SPEED   = 2'd1,
    MODE_TICK        = 2'd2
  } mode_t;

  // Builds a DAC command word: low code byte on top, command and channel in the
  // middle, high code byte at the bottom.
  function automatic logic [WORD_W-1:0] dac_word_f(input logic [2:0] cmd,
                                                   input logic [CHAN_W-1:0] ch,
                                                   input logic [CODE_W-1:0] code);
    dac_word_f = {code[7:0], 10'b0, cmd, 1'b0, ch, code[15:8]};
  endfunction

endpackage

// ----- hw/rtl/four_phase_dds_dac_driver.sv -----
// Four-phase DDS waveform generator driving a four-channel DAC over a stream port.
// Depends on fpdds_pkg for widths, command codes and the word formatter.
// Ticks and speed sets pass the read stage register, then the output register.
// After a tick, input waits while channels 1 to 3 are read, since the waveform table
// has a single read port (one entry read per cycle unless the output stalls).
// Reset (synchronous, active low) clears phase, step, configuration registers and
// all valid flags; the waveform table is undefined until written and never cleared.
module four_phase_dds_dac_driver #(
  parameter int TABLE_DEPTH = fpdds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata from bit 0: table_addr[9:0], table_data[15:0], speed_request[15:0], zeros.
  input  logic [fpdds_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser from bit 0: mode[1:0].
  input  logic [fpdds_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata from bit 0: dac_word[31:0], channel[1:0], zeros.
  output logic [fpdds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser from bit 0: status.
  output logic [fpdds_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                               out_tlast,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fpdds_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [fpdds_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [fpdds_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import fpdds_pkg::*;

  // Table address width and number of phase bits used as the index.
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IDX_W = $clog2(TABLE_DEPTH + 1) - 1;

  // Input field unpacking.
  logic [TADDR_W-1:0]        in_taddr;
  logic [CODE_W-1:0]         in_tcode;
  logic signed [SPEED_W-1:0] in_speed;
  mode_t                     in_mode;

  assign in_taddr = in_tdata[TADDR_W-1:0];
  assign in_tcode = in_tdata[TADDR_W+CODE_W-1:TADDR_W];
  assign in_speed = $signed(in_tdata[TADDR_W+CODE_W+SPEED_W-1:TADDR_W+CODE_W]);
  assign in_mode  = mode_t'(in_tuser);

  // Configuration registers.
  logic [LIMIT_W-1:0] speed_limit_r;
  logic [SCALE_W-1:0] freq_scale_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= '0;
      freq_scale_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SPEED_LIMIT: speed_limit_r <= cfg_pwdata[LIMIT_W-1:0];
        REG_FREQ_SCALE:  freq_scale_r  <= cfg_pwdata[SCALE_W-1:0];
        default:         speed_limit_r <= speed_limit_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[2])
      REG_SPEED_LIMIT: cfg_prdata = CFG_DATA_W'(speed_limit_r);
      REG_FREQ_SCALE:  cfg_prdata = CFG_DATA_W'(freq_scale_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Pipeline control: read stage feeds the output register.
  logic out_valid_r;
  logic rd_valid_r;
  logic seq_busy_r;
  logic o_load;
  logic r_free;
  logic in_xfer;
  logic acc_write;
  logic acc_speed;
  logic acc_tick;
  logic seq_issue;
  logic rd_issue;

  assign o_load    = !out_valid_r || out_tready;
  assign r_free    = !rd_valid_r || o_load;
  assign in_tready = !seq_busy_r && r_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign acc_write = in_xfer && (in_mode == MODE_TABLE_WRITE);
  assign acc_speed = in_xfer && (in_mode == MODE_SET_SPEED);
  assign acc_tick  = in_xfer && (in_mode == MODE_TICK);
  assign seq_issue = seq_busy_r && r_free;
  assign rd_issue  = acc_tick || seq_issue;

  // Speed request range check and step computation.
  logic signed [LIMIT_W+1:0] lim_pos;
  logic signed [LIMIT_W+1:0] lim_neg;
  logic signed [LIMIT_W+1:0] req_ext;
  logic                      speed_bad;
  logic signed [PHASE_W:0]   speed_prod;

  assign lim_pos    = $signed({2'b00, speed_limit_r});
  assign lim_neg    = -lim_pos;
  assign req_ext    = (LIMIT_W + 2)'(in_speed);
  assign speed_bad  = (req_ext > lim_pos) || (req_ext < lim_neg);
  assign speed_prod = in_speed * $signed({1'b0, freq_scale_r});

  // Phase accumulator and step.
  logic [PHASE_W-1:0] phase_acc_r;
  logic [PHASE_W-1:0] phase_acc_nxt;
  logic [PHASE_W-1:0] phase_step_r;
  logic [PHASE_W-1:0] phase_step_nxt;
  logic [PHASE_W-1:0] phase_sum;

  assign phase_sum = phase_acc_r + phase_step_r;

  always_comb begin
    phase_acc_nxt  = acc_tick ? phase_sum : phase_acc_r;
    phase_step_nxt = (acc_speed && !speed_bad) ? speed_prod[PHASE_W-1:0] : phase_step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= '0;
    end else begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
    end
  end

  // Channel sequencer: channel 0 is read on the tick transfer, 1 to 3 after it.
  logic [CHAN_W-1:0] seq_cnt_r;
  logic [CHAN_W-1:0] seq_cnt_nxt;
  logic              seq_busy_nxt;

  always_comb begin
    seq_cnt_nxt  = seq_cnt_r;
    seq_busy_nxt = seq_busy_r;
    if (acc_tick) begin
      seq_cnt_nxt  = CHAN_W'(1);
      seq_busy_nxt = 1'b1;
    end else if (seq_issue) begin
      seq_cnt_nxt = seq_cnt_r + CHAN_W'(1);
      if (seq_cnt_r == CHAN_LAST) begin
        seq_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r  <= '0;
      seq_busy_r <= 1'b0;
    end else begin
      seq_cnt_r  <= seq_cnt_nxt;
      seq_busy_r <= seq_busy_nxt;
    end
  end

  // Table index for the channel being read.
  logic [CHAN_W-1:0]  rd_chan;
  logic [PHASE_W-1:0] cur_phase;
  logic [PHASE_W-1:0] chan_phase;
  logic [IDX_W-1:0]   rd_idx;
  logic [AW-1:0]      rd_addr;

  assign rd_chan   = acc_tick ? '0 : seq_cnt_r;
  assign cur_phase = acc_tick ? phase_sum : phase_acc_r;

  always_comb begin
    case (rd_chan)
      2'd0:    chan_phase = cur_phase;
      2'd1:    chan_phase = ~cur_phase;
      2'd2:    chan_phase = cur_phase ^ HALF_TURN;
      default: chan_phase = ~cur_phase ^ HALF_TURN;
    endcase
  end

  assign rd_idx  = chan_phase[PHASE_W-1 -: IDX_W];
  assign rd_addr = AW'(rd_idx);

  // Waveform table: one write and one registered read per cycle.
  logic [CODE_W-1:0] wave_mem [TABLE_DEPTH];
  logic [CODE_W-1:0] mem_q_r;
  logic              tbl_we;
  logic [AW-1:0]     wr_addr;

  assign tbl_we  = acc_write && (32'(in_taddr) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_taddr);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      wave_mem[wr_addr] <= in_tcode;
    end
    if (rd_issue) begin
      mem_q_r <= wave_mem[rd_addr];
    end
  end

  // Read stage tag: a table word for a channel, or a speed status.
  logic              rd_valid_nxt;
  logic              rd_is_status_r;
  logic              rd_status_r;
  logic [CHAN_W-1:0] rd_chan_r;

  assign rd_valid_nxt = rd_issue || acc_speed || (rd_valid_r && !o_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_is_status_r <= 1'b0;
      rd_status_r    <= 1'b0;
      rd_chan_r      <= rd_chan;
    end else if (acc_speed) begin
      rd_is_status_r <= 1'b1;
      rd_status_r    <= speed_bad;
      rd_chan_r      <= '0;
    end
  end

  // Result formatting from the read stage.
  logic [WORD_W-1:0] res_word;
  logic              res_last;
  logic [2:0]        res_cmd;

  assign res_cmd  = (rd_chan_r == CHAN_LAST) ? CMD_LOAD_LATCH : CMD_LOAD;
  assign res_word = rd_is_status_r ? '0 : dac_word_f(res_cmd, rd_chan_r, mem_q_r);
  assign res_last = rd_is_status_r || (rd_chan_r == CHAN_LAST);

  // Output register.
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic              out_last_r;
  logic              out_status_r;

  assign out_valid_nxt = o_load ? rd_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && rd_valid_r) begin
      out_word_r   <= res_word;
      out_chan_r   <= rd_chan_r;
      out_last_r   <= res_last;
      out_status_r <= rd_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - WORD_W - CHAN_W)'(0), out_chan_r, out_word_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
